[rtl/srg_pkg.sv]
// Package for the subtractive random generator core.
// Holds the word types, arithmetic constants, helper functions and the microprogram.
// No dependencies.
package srg_pkg;

    typedef logic [29:0] t_word;
    typedef logic [5:0]  t_addr;
    typedef logic [2:0]  t_upc;

    localparam t_word MODULUS     = 30'd1000000000;
    localparam t_word SEED_BASE   = 30'd161803398;
    localparam t_addr TABLE_LAST  = 6'd55;
    localparam t_addr TABLE_FIRST = 6'd1;
    localparam t_addr SEED_STRIDE = 6'd21;
    localparam t_addr LAG_START   = 6'd31;
    localparam t_addr WARM_SECOND = 6'd32;
    localparam logic [7:0] SEED_COUNT = 8'd53;
    localparam logic [7:0] WARM_COUNT = 8'd219;

    // Microprogram step addresses.
    localparam t_upc P_IDLE      = 3'd0;
    localparam t_upc P_SEED0     = 3'd1;
    localparam t_upc P_SEED_LOOP = 3'd2;
    localparam t_upc P_WARM0     = 3'd3;
    localparam t_upc P_WARM_RD   = 3'd4;
    localparam t_upc P_WARM_WR   = 3'd5;
    localparam t_upc P_DRAW_RD   = 3'd6;
    localparam t_upc P_DRAW_WR   = 3'd7;

    // Datapath actions.
    localparam logic [2:0] A_NONE       = 3'd0;
    localparam logic [2:0] A_ACCEPT     = 3'd1;
    localparam logic [2:0] A_SEED_START = 3'd2;
    localparam logic [2:0] A_SEED_STEP  = 3'd3;
    localparam logic [2:0] A_WARM_START = 3'd4;
    localparam logic [2:0] A_WARM_STEP  = 3'd5;
    localparam logic [2:0] A_SET_SEEDED = 3'd6;
    localparam logic [2:0] A_DRAW_WR    = 3'd7;

    // Jump conditions.
    localparam logic [1:0] C_NEVER  = 2'd0;
    localparam logic [1:0] C_ALWAYS = 2'd1;
    localparam logic [1:0] C_DRAW   = 2'd2;
    localparam logic [1:0] C_CNT_NZ = 2'd3;

    // Hold conditions.
    localparam logic [1:0] W_NONE   = 2'd0;
    localparam logic [1:0] W_INPUT  = 2'd1;
    localparam logic [1:0] W_OUTPUT = 2'd2;

    typedef struct packed {
        logic       rd_next;
        logic [1:0] hold;
        logic [1:0] cond;
        logic [2:0] act;
        t_upc       target;
    } t_uword;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        begin
            unique case (pc)
                P_IDLE:      w = '{1'b1, W_INPUT,  C_DRAW,   A_ACCEPT,     P_DRAW_WR};
                P_SEED0:     w = '{1'b0, W_NONE,   C_NEVER,  A_SEED_START, P_IDLE};
                P_SEED_LOOP: w = '{1'b0, W_NONE,   C_CNT_NZ, A_SEED_STEP,  P_SEED_LOOP};
                P_WARM0:     w = '{1'b0, W_NONE,   C_NEVER,  A_WARM_START, P_IDLE};
                P_WARM_RD:   w = '{1'b0, W_NONE,   C_NEVER,  A_NONE,       P_IDLE};
                P_WARM_WR:   w = '{1'b0, W_NONE,   C_CNT_NZ, A_WARM_STEP,  P_WARM_RD};
                P_DRAW_RD:   w = '{1'b0, W_NONE,   C_NEVER,  A_SET_SEEDED, P_IDLE};
                P_DRAW_WR:   w = '{1'b0, W_OUTPUT, C_ALWAYS, A_DRAW_WR,    P_IDLE};
                default:     w = '{1'b0, W_NONE,   C_ALWAYS, A_NONE,       P_IDLE};
            endcase
            return w;
        end
    endfunction

    function automatic t_word sub_mod(input t_word a, input t_word b);
        logic [30:0] s;
        begin
            if (a >= b) begin
                s = {1'b0, a} - {1'b0, b};
            end else begin
                s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
            end
            return s[29:0];
        end
    endfunction

    function automatic t_addr advance(input t_addr p);
        begin
            return (p == TABLE_LAST) ? TABLE_FIRST : p + 6'd1;
        end
    endfunction

endpackage

[rtl/subtractive_random_generator_core.sv]
// Top level of the subtractive lagged random generator: microcoded sequencer and lag table.
// Depends on srg_pkg for types, constants, arithmetic helpers and the microprogram.
//
// Channel  Direction  Handshake                   Word fields
// input    in         i_in_valid / o_in_stall     i_reseed, i_seed_magnitude
// output   out        o_out_valid / i_out_stall   o_value
//
// A plain draw reads both lag words on the table's two read ports in the accept cycle,
// and the next step writes the difference back and loads the output register.
// A draw that rebuilds the table runs 54 seeding steps and then 220 warm-up subtractions,
// each split into a read step and a write step through the single write port.
// Reset idles the sequencer, resets the pointers and clears the seeded flag; the table is
// rebuilt on the first draw. An output stall holds the sequencer in the write-back step,
// and a new word is taken while an earlier result still waits in the output register.
module subtractive_random_generator_core
    import srg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_reseed,
    input  logic [29:0] i_seed_magnitude,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [29:0] o_value
);

    t_word  r_mem [0:55];

    t_upc   r_upc, n_upc;
    t_addr  r_fp, n_fp;
    t_addr  r_sp, n_sp;
    t_addr  r_pos, n_pos;
    logic   [7:0] r_cnt, n_cnt;
    logic   r_seeded, n_seeded;
    t_word  r_seed, n_seed;
    t_word  r_m, n_m;
    t_word  r_k, n_k;
    t_word  r_rd_a, r_rd_b;
    logic   r_out_valid, n_out_valid;
    t_word  r_out_value, n_out_value;

    t_uword w;
    logic   hold;
    logic   take;
    logic   need_seed;
    logic   we;
    t_addr  wa;
    t_word  wd;
    t_addr  ra_a, ra_b;
    t_word  diff;
    t_word  m_start;
    logic   [6:0] pos_sum;

    assign w         = ucode(r_upc);
    assign need_seed = i_reseed || !r_seeded;
    assign diff      = sub_mod(r_rd_a, r_rd_b);
    assign m_start   = (r_seed > SEED_BASE) ? (SEED_BASE + MODULUS - r_seed)
                                            : (SEED_BASE - r_seed);
    assign pos_sum   = {1'b0, r_pos} + {1'b0, SEED_STRIDE};
    assign ra_a      = w.rd_next ? advance(r_fp) : r_fp;
    assign ra_b      = w.rd_next ? advance(r_sp) : r_sp;

    always_comb begin
        hold = 1'b0;
        case (w.hold)
            W_INPUT:  hold = !i_in_valid;
            W_OUTPUT: hold = r_out_valid && i_out_stall;
            default:  hold = 1'b0;
        endcase
    end

    always_comb begin
        take = 1'b0;
        unique case (w.cond)
            C_NEVER:  take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_DRAW:   take = !need_seed;
            C_CNT_NZ: take = (r_cnt != 8'd0);
            default:  take = 1'b0;
        endcase
    end

    always_comb begin
        n_upc       = r_upc;
        n_fp        = r_fp;
        n_sp        = r_sp;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_seeded    = r_seeded;
        n_seed      = r_seed;
        n_m         = r_m;
        n_k         = r_k;
        n_out_value = r_out_value;
        n_out_valid = r_out_valid && i_out_stall;
        we          = 1'b0;
        wa          = r_fp;
        wd          = diff;
        if (!hold) begin
            n_upc = take ? w.target : r_upc + 3'd1;
            unique case (w.act)
                A_NONE: begin
                end
                A_ACCEPT: begin
                    n_seed = i_seed_magnitude;
                    if (!need_seed) begin
                        n_fp = advance(r_fp);
                        n_sp = advance(r_sp);
                    end
                end
                A_SEED_START: begin
                    we    = 1'b1;
                    wa    = TABLE_LAST;
                    wd    = m_start;
                    n_m   = m_start;
                    n_k   = 30'd1;
                    n_pos = SEED_STRIDE;
                    n_cnt = SEED_COUNT;
                end
                A_SEED_STEP: begin
                    we    = 1'b1;
                    wa    = r_pos;
                    wd    = r_k;
                    n_k   = sub_mod(r_m, r_k);
                    n_m   = r_k;
                    n_pos = (pos_sum >= {1'b0, TABLE_LAST}) ? 6'(pos_sum - {1'b0, TABLE_LAST})
                                                            : pos_sum[5:0];
                    n_cnt = r_cnt - 8'd1;
                end
                A_WARM_START: begin
                    n_fp  = TABLE_FIRST;
                    n_sp  = WARM_SECOND;
                    n_cnt = WARM_COUNT;
                end
                A_WARM_STEP: begin
                    we    = 1'b1;
                    n_fp  = advance(r_fp);
                    n_sp  = advance(r_sp);
                    n_cnt = r_cnt - 8'd1;
                end
                A_SET_SEEDED: begin
                    n_seeded = 1'b1;
                end
                A_DRAW_WR: begin
                    we          = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_value = diff;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_a <= r_mem[ra_a];
        r_rd_b <= r_mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= P_IDLE;
            r_fp        <= 6'd0;
            r_sp        <= LAG_START;
            r_cnt       <= 8'd0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_fp        <= n_fp;
            r_sp        <= n_sp;
            r_cnt       <= n_cnt;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_seed      <= n_seed;
        r_m         <= n_m;
        r_k         <= n_k;
        r_out_value <= n_out_value;
    end

    assign o_in_stall  = (r_upc != P_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

endmodule

[rtl/srg_checker.sv]
// Port-level checker for the subtractive random generator core, with its bind statement.
// Depends only on the ports of subtractive_random_generator_core.
module srg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_reseed,
    input logic [29:0] i_seed_magnitude,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [29:0] o_value
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset did not leave the block empty and ready.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Block took a second word before finishing the first.");

    a_value_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_value <= 30'd999999999)
        else $error("Result word is not below the modulus.");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value))
        else $error("Stalled result word changed or vanished.");

endmodule

bind subtractive_random_generator_core srg_checker u_srg_checker (.*);

[bench/srg_draw_checker.sv]
// Checker for the subtractive random generator core: watches both word channels,
// predicts each drawn value from its own copy of the lag table and compares in order.
// Depends on srg_pkg for the word types and the arithmetic constants.
module srg_draw_checker
    import srg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_reseed,
    input  logic [29:0] i_seed_magnitude,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [29:0] i_value,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    t_word lag_words [0:55];
    t_addr lead_slot;
    t_addr trail_slot;
    logic  primed;
    t_word expected_values [$];
    int    mismatches = 0;

    function automatic t_word wrap_sub(input t_word a, input t_word b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) begin
            d = d + longint'(MODULUS);
        end
        return t_word'(d);
    endfunction

    function automatic t_addr step_slot(input t_addr p);
        return (p == TABLE_LAST) ? TABLE_FIRST : t_addr'(p + 1);
    endfunction

    function automatic void refill(input logic [29:0] seed);
        longint start;
        t_word  carry;
        t_word  prev;
        int     pos;
        int     i;
        int     j;
        int     pass;
        start = longint'(SEED_BASE) - longint'(seed);
        if (start < 0) begin
            start = start + longint'(MODULUS);
        end
        lag_words[55] = t_word'(start);
        prev = t_word'(start);
        carry = 30'd1;
        for (i = 1; i <= 54; i++) begin
            pos = (21 * i) % 55;
            lag_words[pos] = carry;
            carry = wrap_sub(prev, carry);
            prev = lag_words[pos];
        end
        for (pass = 0; pass < 4; pass++) begin
            for (i = 1; i <= 55; i++) begin
                j = 1 + ((i + 30) % 55);
                lag_words[i] = wrap_sub(lag_words[i], lag_words[j]);
            end
        end
        lead_slot = 6'd0;
        trail_slot = LAG_START;
        primed = 1'b1;
    endfunction

    function automatic t_word draw_value(input logic reseed, input logic [29:0] seed);
        t_word d;
        if (reseed || !primed) begin
            refill(seed);
        end
        lead_slot = step_slot(lead_slot);
        trail_slot = step_slot(trail_slot);
        d = wrap_sub(lag_words[lead_slot], lag_words[trail_slot]);
        lag_words[lead_slot] = d;
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            primed = 1'b0;
            lead_slot = 6'd0;
            trail_slot = LAG_START;
            expected_values.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_values.push_back(draw_value(i_reseed, i_seed_magnitude));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_values.size() == 0) begin
                    mismatches++;
                    $display("%0t: no value expected, got %0d", $time, i_value);
                end else begin
                    want = expected_values.pop_front();
                    if (i_value !== want) begin
                        mismatches++;
                        $display("%0t: value expected %0d, got %0d", $time, want, i_value);
                    end
                end
            end
        end
        o_outstanding <= expected_values.size();
        o_mismatches <= mismatches;
    end

endmodule

[bench/tb_subtractive_random_generator_core.sv]
// Testbench top for the subtractive random generator core: drives draw requests with
// random gaps and output stalls, and gives the verdict from the checker's count.
// Depends on srg_pkg, subtractive_random_generator_core and srg_draw_checker.
module tb_subtractive_random_generator_core
    import srg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT   = 550;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 32;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        reseed;
    logic [29:0] seed_magnitude;
    logic        out_valid;
    logic        out_stall;
    logic [29:0] value;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    int          received = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    subtractive_random_generator_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_reseed         (reseed),
        .i_seed_magnitude (seed_magnitude),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_value          (value)
    );

    srg_draw_checker checker_i (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_reseed         (reseed),
        .i_seed_magnitude (seed_magnitude),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_value          (value),
        .o_mismatches     (fail_count),
        .o_outstanding    (pending)
    );

    function automatic logic [29:0] pick_seed();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 6))
                    0: return 30'd0;
                    1: return 30'd1;
                    2: return SEED_BASE - 30'd1;
                    3: return SEED_BASE;
                    4: return SEED_BASE + 30'd1;
                    5: return MODULUS - 30'd1;
                    default: return 30'h3FFFFFFF;
                endcase
            end
            1: return 30'($urandom_range(0, 999999999));
            default: return r[29:0];
        endcase
    endfunction

    task automatic send_draw(input logic rs, input logic [29:0] seed);
        int gap;
        gap = ((sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        reseed <= rs;
        seed_magnitude <= seed;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int hold;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            hold = ((received / 40) % 4 == 1) ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
            received++;
        end
    end

    initial begin
        int run;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        reseed <= 1'b0;
        seed_magnitude <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The first draw after reset rebuilds the table even without reseed.
        send_draw(1'b0, 30'h3FFFFFFF);
        send_draw(1'b0, 30'($urandom));
        send_draw(1'b0, 30'($urandom));
        send_draw(1'b1, 30'd0);
        send_draw(1'b0, 30'd0);
        send_draw(1'b1, SEED_BASE);
        send_draw(1'b1, SEED_BASE + 30'd1);
        send_draw(1'b0, 30'h3FFFFFFF);
        send_draw(1'b1, MODULUS - 30'd1);
        send_draw(1'b1, MODULUS);
        send_draw(1'b1, 30'd1);
        send_draw(1'b1, SEED_BASE - 30'd1);
        send_draw(1'b1, 30'h2AAAAAAA);
        send_draw(1'b1, 30'h15555555);
        send_draw(1'b0, 30'h2AAAAAAA);

        while (sent < ITEM_COUNT) begin
            send_draw(1'b1, pick_seed());
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(56, 130)
                                              : $urandom_range(0, 30);
            repeat (run) begin
                if (sent < ITEM_COUNT) begin
                    send_draw(1'b0, 30'($urandom));
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
